/* rtl/core/cpe_pkg.sv */
// shared constants and types for the complex polynomial evaluator
// no dependencies; imported by cpe_cmul, complex_polynomial_evaluator and tb
package cpe_pkg;

    localparam int MAX_TERMS  = 64;
    localparam int PART_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_TERMS);
    localparam int COUNT_W    = 7;
    localparam int COEF_W     = 2 * PART_WIDTH;

    // one in fixed point, clipped when it does not fit
    localparam logic signed [PART_WIDTH-1:0] PART_ONE =
        (FRAC_BITS < PART_WIDTH - 1) ? (PART_WIDTH'(1) << FRAC_BITS)
                                     : {1'b0, {(PART_WIDTH-1){1'b1}}};

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_t;

    typedef enum logic
    {
        TAG_TERM  = 1'b0,
        TAG_POWER = 1'b1
    } mul_tag_t;

    typedef struct packed
    {
        cmd_t                          command;
        logic [5:0]                    coef_index;
        logic signed [31:0]            coef_real;
        logic signed [31:0]            coef_imag;
        logic signed [31:0]            point_real;
        logic signed [31:0]            point_imag;
    } in_item_t;

    typedef struct packed
    {
        logic signed [31:0]            value_real;
        logic signed [31:0]            value_imag;
        logic                          overflow;
    } out_item_t;

    typedef struct packed
    {
        logic     valid;
        mul_tag_t tag;
    } cmul_ctl_t;

    typedef struct packed
    {
        logic     valid;
        mul_tag_t tag;
        logic     ovf;
    } cmul_res_t;

endpackage

/* rtl/core/cpe_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module cpe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/cpe_cmul.sv */
// two stage complex multiplier: products, then exact combine, round and saturate
// depends on cpe_pkg
module cpe_cmul (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cpe_pkg::cmul_ctl_t                     ctl,
    input  logic signed [cpe_pkg::PART_WIDTH-1:0]  ar,
    input  logic signed [cpe_pkg::PART_WIDTH-1:0]  ai,
    input  logic signed [cpe_pkg::PART_WIDTH-1:0]  br,
    input  logic signed [cpe_pkg::PART_WIDTH-1:0]  bi,
    output cpe_pkg::cmul_res_t                     res,
    output logic signed [cpe_pkg::PART_WIDTH-1:0]  res_real,
    output logic signed [cpe_pkg::PART_WIDTH-1:0]  res_imag
);
    import cpe_pkg::*;

    localparam int PROD_W = 2 * PART_WIDTH;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] HALF    = (ACC_W'(1) << FRAC_BITS) >> 1;
    localparam logic signed [ACC_W-1:0] ACC_MAX =
        {{(ACC_W-PART_WIDTH+1){1'b0}}, {(PART_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN =
        {{(ACC_W-PART_WIDTH+1){1'b1}}, {(PART_WIDTH-1){1'b0}}};

    cmul_ctl_t                 ctl1_reg;
    logic signed [PROD_W-1:0]  p_rr_reg;
    logic signed [PROD_W-1:0]  p_ii_reg;
    logic signed [PROD_W-1:0]  p_ir_reg;
    logic signed [PROD_W-1:0]  p_ri_reg;

    logic signed [ACC_W-1:0]   re_acc;
    logic signed [ACC_W-1:0]   im_acc;
    logic signed [ACC_W-1:0]   re_shift;
    logic signed [ACC_W-1:0]   im_shift;
    logic signed [PART_WIDTH-1:0] re_sat;
    logic signed [PART_WIDTH-1:0] im_sat;
    logic                      re_ovf;
    logic                      im_ovf;

    cmul_res_t                 res_reg;
    logic signed [PART_WIDTH-1:0] res_real_reg;
    logic signed [PART_WIDTH-1:0] res_imag_reg;

    // exact sums, round half up, floor shift
    always_comb
    begin
        re_acc   = ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg) + HALF;
        im_acc   = ACC_W'(p_ir_reg) + ACC_W'(p_ri_reg) + HALF;
        re_shift = re_acc >>> FRAC_BITS;
        im_shift = im_acc >>> FRAC_BITS;
        re_ovf   = (re_shift > ACC_MAX) || (re_shift < ACC_MIN);
        im_ovf   = (im_shift > ACC_MAX) || (im_shift < ACC_MIN);
        if (re_shift > ACC_MAX)
        begin
            re_sat = ACC_MAX[PART_WIDTH-1:0];
        end
        else if (re_shift < ACC_MIN)
        begin
            re_sat = ACC_MIN[PART_WIDTH-1:0];
        end
        else
        begin
            re_sat = re_shift[PART_WIDTH-1:0];
        end
        if (im_shift > ACC_MAX)
        begin
            im_sat = ACC_MAX[PART_WIDTH-1:0];
        end
        else if (im_shift < ACC_MIN)
        begin
            im_sat = ACC_MIN[PART_WIDTH-1:0];
        end
        else
        begin
            im_sat = im_shift[PART_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            ctl1_reg    <= ctl;
            res_reg.valid <= ctl1_reg.valid;
            res_reg.tag   <= ctl1_reg.tag;
            res_reg.ovf   <= ctl1_reg.valid && (re_ovf || im_ovf);
        end
    end

    always_ff @(posedge clk)
    begin
        p_rr_reg     <= PROD_W'(ar) * PROD_W'(br);
        p_ii_reg     <= PROD_W'(ai) * PROD_W'(bi);
        p_ir_reg     <= PROD_W'(ai) * PROD_W'(br);
        p_ri_reg     <= PROD_W'(bi) * PROD_W'(ar);
        res_real_reg <= re_sat;
        res_imag_reg <= im_sat;
    end

    assign res      = res_reg;
    assign res_real = res_real_reg;
    assign res_imag = res_imag_reg;

endmodule

/* rtl/core/complex_polynomial_evaluator.sv */
// top level: command decode, evaluation sequencer, running power and sum
// depends on cpe_pkg, cpe_ram, cpe_cmul
//
// usage
//   item channel: raise start with item; a transaction is taken at the clock
//   edge where start is high and busy is low. command CMD_LOAD writes one
//   coefficient at coef_index and gives no result. command
//   CMD_EVAL evaluates sum of c_i * x^i over the first term_count terms.
//   result channel: result_valid is high for exactly one cycle with result;
//   the receiver cannot hold it off and must take it in that cycle.
//   config: cfg_we with cfg_data writes term_count (values above 64 act as 64);
//   write it only while the block is idle.
// sequencing
//   an evaluate raises result_valid once its last term has been added into
//   the sum, or in the cycle after acceptance for zero terms; busy stays
//   high until the result cycle, and a new transaction can be taken in the
//   result cycle itself. each term waits for the running power x^i to make
//   its round trip through the two stage complex multiplier before the next.
// reset
//   rst_n clears the sequencer, term_count and the running sum; coefficient
//   storage is not cleared and must be loaded before it is evaluated.
module complex_polynomial_evaluator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  cpe_pkg::in_item_t               item,
    input  logic                            cfg_we,
    input  logic [cpe_pkg::COUNT_W-1:0]     cfg_data,
    output logic                            result_valid,
    output cpe_pkg::out_item_t              result
);
    import cpe_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_MUL_C,
        S_MUL_X,
        S_WAIT,
        S_DRAIN
    } state_t;

    state_t                        state_reg, state_next;
    logic [COUNT_W-1:0]            term_count_reg;
    logic [IDX_W-1:0]              term_idx_reg, term_idx_next;
    logic [IDX_W-1:0]              last_reg, last_next;
    logic signed [PART_WIDTH-1:0]  x_real_reg, x_real_next;
    logic signed [PART_WIDTH-1:0]  x_imag_reg, x_imag_next;
    logic signed [PART_WIDTH-1:0]  power_real_reg, power_real_next;
    logic signed [PART_WIDTH-1:0]  power_imag_reg, power_imag_next;
    logic signed [PART_WIDTH-1:0]  sum_real_reg, sum_real_next;
    logic signed [PART_WIDTH-1:0]  sum_imag_reg, sum_imag_next;
    logic                          ovf_reg, ovf_next;
    logic                          result_valid_reg, result_valid_next;

    logic [COUNT_W-1:0]            n_terms;
    logic                          accept;
    logic                          ram_we;
    logic                          ram_re;
    logic [IDX_W-1:0]              ram_raddr;
    logic [COEF_W-1:0]             ram_rdata;

    cmul_ctl_t                     mul_ctl;
    cmul_res_t                     mul_res;
    logic signed [PART_WIDTH-1:0]  mul_br;
    logic signed [PART_WIDTH-1:0]  mul_bi;
    logic signed [PART_WIDTH-1:0]  mul_real;
    logic signed [PART_WIDTH-1:0]  mul_imag;

    logic signed [PART_WIDTH:0]    add_real;
    logic signed [PART_WIDTH:0]    add_imag;
    logic signed [PART_WIDTH-1:0]  add_real_sat;
    logic signed [PART_WIDTH-1:0]  add_imag_sat;
    logic                          add_real_ovf;
    logic                          add_imag_ovf;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign ram_we = accept && (item.command == CMD_LOAD);
    assign n_terms = (term_count_reg > COUNT_W'(MAX_TERMS)) ? COUNT_W'(MAX_TERMS)
                                                           : term_count_reg;

    cpe_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TERMS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item.coef_index[IDX_W-1:0]),
        .wdata ({item.coef_real[PART_WIDTH-1:0], item.coef_imag[PART_WIDTH-1:0]}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cpe_cmul u_cmul (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mul_ctl),
        .ar       (power_real_reg),
        .ai       (power_imag_reg),
        .br       (mul_br),
        .bi       (mul_bi),
        .res      (mul_res),
        .res_real (mul_real),
        .res_imag (mul_imag)
    );

    // saturating add of a finished term into the sum
    always_comb
    begin
        add_real     = {sum_real_reg[PART_WIDTH-1], sum_real_reg}
                     + {mul_real[PART_WIDTH-1], mul_real};
        add_imag     = {sum_imag_reg[PART_WIDTH-1], sum_imag_reg}
                     + {mul_imag[PART_WIDTH-1], mul_imag};
        add_real_ovf = add_real[PART_WIDTH] != add_real[PART_WIDTH-1];
        add_imag_ovf = add_imag[PART_WIDTH] != add_imag[PART_WIDTH-1];
        if (add_real_ovf)
        begin
            add_real_sat = {add_real[PART_WIDTH], {(PART_WIDTH-1){!add_real[PART_WIDTH]}}};
        end
        else
        begin
            add_real_sat = add_real[PART_WIDTH-1:0];
        end
        if (add_imag_ovf)
        begin
            add_imag_sat = {add_imag[PART_WIDTH], {(PART_WIDTH-1){!add_imag[PART_WIDTH]}}};
        end
        else
        begin
            add_imag_sat = add_imag[PART_WIDTH-1:0];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        term_idx_next     = term_idx_reg;
        last_next         = last_reg;
        x_real_next       = x_real_reg;
        x_imag_next       = x_imag_reg;
        power_real_next   = power_real_reg;
        power_imag_next   = power_imag_reg;
        sum_real_next     = sum_real_reg;
        sum_imag_next     = sum_imag_reg;
        ovf_next          = ovf_reg;
        result_valid_next = 1'b0;
        ram_re            = 1'b0;
        ram_raddr         = term_idx_reg;
        mul_ctl.valid     = 1'b0;
        mul_ctl.tag       = TAG_TERM;
        mul_br            = ram_rdata[COEF_W-1:PART_WIDTH];
        mul_bi            = ram_rdata[PART_WIDTH-1:0];

        // returning products from the multiplier
        if (mul_res.valid)
        begin
            if (mul_res.tag == TAG_TERM)
            begin
                sum_real_next = add_real_sat;
                sum_imag_next = add_imag_sat;
                ovf_next      = ovf_reg || mul_res.ovf || add_real_ovf || add_imag_ovf;
            end
            else
            begin
                power_real_next = mul_real;
                power_imag_next = mul_imag;
                ovf_next        = ovf_reg || mul_res.ovf;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && (item.command == CMD_EVAL))
                begin
                    power_real_next = PART_ONE;
                    power_imag_next = '0;
                    sum_real_next   = '0;
                    sum_imag_next   = '0;
                    ovf_next        = 1'b0;
                    x_real_next     = item.point_real[PART_WIDTH-1:0];
                    x_imag_next     = item.point_imag[PART_WIDTH-1:0];
                    term_idx_next   = '0;
                    if (n_terms == '0)
                    begin
                        result_valid_next = 1'b1;
                    end
                    else
                    begin
                        last_next  = IDX_W'(n_terms - COUNT_W'(1));
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = S_MUL_C;
                    end
                end
            end
            S_MUL_C:
            begin
                mul_ctl.valid = 1'b1;
                mul_ctl.tag   = TAG_TERM;
                if (term_idx_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    state_next = S_MUL_X;
                end
            end
            S_MUL_X:
            begin
                mul_ctl.valid = 1'b1;
                mul_ctl.tag   = TAG_POWER;
                mul_br        = x_real_reg;
                mul_bi        = x_imag_reg;
                // prefetch the next coefficient while the power is in flight
                term_idx_next = term_idx_reg + IDX_W'(1);
                ram_re        = 1'b1;
                ram_raddr     = term_idx_reg + IDX_W'(1);
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (mul_res.valid && (mul_res.tag == TAG_POWER))
                begin
                    state_next = S_MUL_C;
                end
            end
            S_DRAIN:
            begin
                if (mul_res.valid && (mul_res.tag == TAG_TERM))
                begin
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            term_count_reg   <= '0;
            term_idx_reg     <= '0;
            last_reg         <= '0;
            power_real_reg   <= PART_ONE;
            power_imag_reg   <= '0;
            sum_real_reg     <= '0;
            sum_imag_reg     <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_we)
            begin
                term_count_reg <= cfg_data;
            end
            term_idx_reg     <= term_idx_next;
            last_reg         <= last_next;
            power_real_reg   <= power_real_next;
            power_imag_reg   <= power_imag_next;
            sum_real_reg     <= sum_real_next;
            sum_imag_reg     <= sum_imag_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_real_reg <= x_real_next;
        x_imag_reg <= x_imag_next;
    end

    assign result_valid      = result_valid_reg;
    assign result.value_real = 32'(sum_real_reg);
    assign result.value_imag = 32'(sum_imag_reg);
    assign result.overflow   = ovf_reg;

`ifndef SYNTH
    a_result_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while sequencer busy");

    a_zero_terms_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.command == CMD_EVAL) && (n_terms == '0)) |=> result_valid)
        else $error("zero term evaluate did not return at once");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.command == CMD_LOAD)) |=> (!busy && !result_valid))
        else $error("load transaction started an evaluation");

    a_mul_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mul_res.valid |-> busy)
        else $error("multiplier returned a product with no evaluation running");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (term_idx_reg <= last_reg))
        else $error("term index ran past the last term");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// testbench for complex_polynomial_evaluator: directed corners, then random
// load/evaluate traffic checked in order against an in-bench predictor
// depends on cpe_pkg and the complex_polynomial_evaluator rtl
module tb;
    import cpe_pkg::*;

    typedef logic signed [79:0] wide_t;

    localparam longint PART_HI       = (longint'(1) <<< (PART_WIDTH - 1)) - 1;
    localparam longint PART_LO       = -PART_HI - 1;
    localparam int     SETTLE_CYCLES = 4;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    in_item_t           item     = '0;
    logic               cfg_we   = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;
    logic               busy;
    logic               result_valid;
    out_item_t          result;

    // predictor state
    longint             table_re [MAX_TERMS];
    longint             table_im [MAX_TERMS];
    longint             power_re   = PART_ONE;
    longint             power_im   = 0;
    longint             sum_re     = 0;
    longint             sum_im     = 0;
    logic [COUNT_W-1:0] term_limit = '0;
    bit                 sat_flag;

    out_item_t          pending_values [$];
    int                 load_count     = 0;
    int                 eval_count     = 0;
    int                 result_count   = 0;
    int                 sat_count      = 0;
    int                 mismatch_count = 0;
    int                 idle_pct       = 0;

    complex_polynomial_evaluator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip(wide_t v);
        if (v > PART_HI)
        begin
            sat_flag = 1'b1;
            return PART_HI;
        end
        if (v < PART_LO)
        begin
            sat_flag = 1'b1;
            return PART_LO;
        end
        return longint'(v);
    endfunction

    // exact sum of two products, round half up at the binary point, clip
    function automatic longint round_sum(wide_t p, wide_t q);
        wide_t v;
        v = p + q + (wide_t'(1) <<< (FRAC_BITS - 1));
        return clip(v >>> FRAC_BITS);
    endfunction

    task automatic cmul(input longint ar, input longint ai, input longint br,
                        input longint bi, output longint rr, output longint ri);
        rr = round_sum(wide_t'(ar) * wide_t'(br), -(wide_t'(ai) * wide_t'(bi)));
        ri = round_sum(wide_t'(ai) * wide_t'(br), wide_t'(bi) * wide_t'(ar));
    endtask

    task automatic evaluate_point(input longint x_re, input longint x_im,
                                  output out_item_t res);
        int     n;
        longint t_re;
        longint t_im;
        n        = (term_limit > MAX_TERMS) ? MAX_TERMS : int'(term_limit);
        sat_flag = 1'b0;
        power_re = PART_ONE;
        power_im = 0;
        sum_re   = 0;
        sum_im   = 0;
        for (int i = 0; i < n; i++)
        begin
            cmul(power_re, power_im, table_re[i], table_im[i], t_re, t_im);
            sum_re = clip(wide_t'(sum_re) + wide_t'(t_re));
            sum_im = clip(wide_t'(sum_im) + wide_t'(t_im));
            if (i + 1 < n)
                cmul(power_re, power_im, x_re, x_im, power_re, power_im);
        end
        res.value_real = sum_re[31:0];
        res.value_imag = sum_im[31:0];
        res.overflow   = sat_flag;
    endtask

    task automatic track_item(in_item_t it);
        out_item_t res;
        if (it.command == CMD_LOAD)
        begin
            load_count++;
            if (int'(it.coef_index) < MAX_TERMS)
            begin
                table_re[it.coef_index] = longint'($signed(it.coef_real));
                table_im[it.coef_index] = longint'($signed(it.coef_imag));
            end
        end
        else
        begin
            eval_count++;
            evaluate_point(longint'($signed(it.point_real)),
                           longint'($signed(it.point_imag)), res);
            pending_values.push_back(res);
        end
    endtask

    function automatic in_item_t make_item(cmd_t c, logic [5:0] idx,
                                           logic [31:0] cr, logic [31:0] ci,
                                           logic [31:0] pr, logic [31:0] pi);
        in_item_t it;
        it.command    = c;
        it.coef_index = idx;
        it.coef_real  = cr;
        it.coef_imag  = ci;
        it.point_real = pr;
        it.point_imag = pi;
        return it;
    endfunction

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // start stays high on return unless the sender pauses, so the next call can follow in the same step
    task automatic send_item(in_item_t it);
        item  <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        track_item(it);
        if ($urandom_range(0, 99) < idle_pct)
            pause_sender($urandom_range(1, 12));
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        // a load may still be in flight after the last result
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_terms(logic [COUNT_W-1:0] value);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        term_limit = value;
    endtask

    function automatic logic [31:0] edge_part();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [31:0] coef_part();
        case ($urandom_range(0, 6))
            0, 1, 2: return $urandom_range(0, 1 << 21) - (1 << 20);
            3:       return $urandom();
            4:       return edge_part();
            default: return $urandom_range(0, 1 << 16) - (1 << 15);
        endcase
    endfunction

    // mostly inside the unit circle so long power series stay in range
    function automatic logic [31:0] point_part();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 92000) - 46000;
            6, 7:             return $urandom_range(0, 1 << 19) - (1 << 18);
            8:                return $urandom();
            default:          return edge_part();
        endcase
    endfunction

    // result checker: one transaction per strobe, compared with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            result_count++;
            if (result.overflow === 1'b1)
                sat_count++;
            if (pending_values.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: result with nothing outstanding, got %h", $time, result);
            end
            else
            begin
                want = pending_values.pop_front();
                if (result.value_real !== want.value_real)
                begin
                    mismatch_count++;
                    $display("%0t ns: value_real expected %h got %h",
                             $time, want.value_real, result.value_real);
                end
                if (result.value_imag !== want.value_imag)
                begin
                    mismatch_count++;
                    $display("%0t ns: value_imag expected %h got %h",
                             $time, want.value_imag, result.value_imag);
                end
                if (result.overflow !== want.overflow)
                begin
                    mismatch_count++;
                    $display("%0t ns: overflow expected %b got %b",
                             $time, want.overflow, result.overflow);
                end
            end
        end
    end

    // term count still at its reset value of zero
    task automatic test_empty_eval();
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_item(CMD_EVAL, 6'd63, '1, '1, '0, '0));
        settle();
    endtask

    task automatic test_corner_values();
        send_item(make_item(CMD_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, '1, '0));
        send_item(make_item(CMD_LOAD, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, '0, '1));
        send_item(make_item(CMD_LOAD, 6'd63, '0, '1, '0, '0));
        write_terms(7'd2);
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, '0, '0));
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, '1, '1));
        settle();
    endtask

    // half-lsb products land exactly on a tie and must round upward
    task automatic test_rounding();
        send_item(make_item(CMD_LOAD, 6'd0, '0, '0, '0, '0));
        send_item(make_item(CMD_LOAD, 6'd1, 32'd1, '1, '0, '0));
        write_terms(7'd2);
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, 32'h0000_8000, '0));
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, '0, 32'h0000_8000));
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, 32'hFFFF_8000, '0));
        settle();
    endtask

    task automatic test_real_only();
        send_item(make_item(CMD_LOAD, 6'd0, 32'h0003_0000, '0, '0, '0));
        send_item(make_item(CMD_LOAD, 6'd1, 32'hFFFE_0000, '0, '0, '0));
        send_item(make_item(CMD_LOAD, 6'd2, 32'h0001_0000, '0, '0, '0));
        write_terms(7'd3);
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, 32'h0005_0000, '0));
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, 32'hFFFF_4000, '0));
        settle();
    endtask

    task automatic test_saturation();
        send_item(make_item(CMD_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0));
        send_item(make_item(CMD_LOAD, 6'd1, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0));
        write_terms(7'd2);
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, 32'h0001_0000, '0));
        send_item(make_item(CMD_EVAL, 6'd0, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        settle();
    endtask

    // every entry gets written before any long evaluation reads it
    task automatic test_fill_table();
        idle_pct = 66;
        for (int i = 0; i < MAX_TERMS; i++)
            send_item(make_item(CMD_LOAD, 6'(i), coef_part(), coef_part(),
                                $urandom(), $urandom()));
        settle();
    endtask

    task automatic run_phase(int terms, int pct, int count);
        int          target;
        bit          real_only;
        logic [31:0] pr;
        logic [31:0] pi;
        write_terms(7'(terms));
        idle_pct = pct;
        target   = load_count + eval_count + count;
        while (load_count + eval_count < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // a few coefficient updates, then one or two evaluates
                real_only = ($urandom_range(0, 4) == 0);
                repeat ($urandom_range(0, 4))
                    send_item(make_item(CMD_LOAD, 6'($urandom_range(0, 63)), coef_part(),
                                        real_only ? '0 : coef_part(),
                                        $urandom(), $urandom()));
                pr = point_part();
                pi = real_only ? '0 : point_part();
                repeat ($urandom_range(1, 2))
                    send_item(make_item(CMD_EVAL, 6'($urandom_range(0, 63)),
                                        $urandom(), $urandom(), pr, pi));
            end
            else
            begin
                send_item(make_item(cmd_t'($urandom_range(0, 1)),
                                    6'($urandom_range(0, 63)), $urandom(), $urandom(),
                                    $urandom(), $urandom()));
            end
        end
    endtask

    task automatic test_random_phases();
        int terms_list [10] = '{64, 1, 127, 0, 3, 16, 2, 5, 8, 64};
        int pct_list [3]    = '{0, 66, 7};
        int terms;
        for (int i = 0; i < 10; i++)
        begin
            terms = (i == 5) ? $urandom_range(9, 63) : terms_list[i];
            run_phase(terms, pct_list[i % 3], 103);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_eval();
        test_corner_values();
        test_rounding();
        test_real_only();
        test_saturation();
        test_fill_table();
        test_random_phases();
        settle();
        repeat (16) @(posedge clk);
        if (pending_values.size() != 0)
        begin
            mismatch_count++;
            $display("%0t ns: %0d expected results never arrived", $time,
                     pending_values.size());
        end
        $display("ran %0d loads and %0d evaluates, %0d results checked, %0d saturated",
                 load_count, eval_count, result_count, sat_count);
        $display("term counts 0 to 127, sender idle 0/7/66 percent, ties and clipping");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
